// File: src/btds_pkg.sv
package btds_pkg;

	localparam int BYTE_W      = 8;
	localparam int CODE_W      = 9;
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CMD_W       = 2;
	localparam int KEPT_W      = 16;
	localparam int COUNT_BITS  = 16;
	// wide copy width for the count, sliced down to the kept field
	localparam int WIDE_W      = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_END   = 2'd2,
		CMD_SPARE = 2'd3
	} cmd_t;

	typedef logic [COUNT_BITS-1:0] count_t;
	localparam count_t COUNT_MAX = '1;

endpackage

// File: src/btds_item_if.sv
interface btds_item_if import btds_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic [IDX_W-1:0]         entry_index;
	logic signed [CODE_W-1:0] entry_code;
	logic [BYTE_W-1:0]        data_byte;

	modport source (output valid, cmd, entry_index, entry_code, data_byte, input ready);
	modport sink (input valid, cmd, entry_index, entry_code, data_byte, output ready);
endinterface

// File: src/btds_result_if.sv
interface btds_result_if import btds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              is_end;
	logic [KEPT_W-1:0] kept_count;

	modport source (output valid, out_byte, is_end, kept_count, input ready);
	modport sink (input valid, out_byte, is_end, kept_count, output ready);
endinterface

// File: src/btds_cfg_if.sv
interface btds_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: src/btds_ram.sv
module btds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: src/byte_translate_delete_squeeze_unit.sv
// Byte translate / delete / squeeze engine.
// items (sink): cmd selects the work. A write item loads code_table[entry_index]
//   with entry_code (negative deletes, zero passes, 1..255 replaces). A data
//   item translates data_byte. An end item closes the string. cmd 3 is dropped.
// results (source): one item per emitted byte (is_end 0) and one per end item
//   (is_end 1, kept_count = bytes kept, saturating). Deleted and squeezed bytes
//   and write items give no result.
// cfg (sink): one bit, squeeze_enable; always ready, write it while idle.
// Path: a data or end item goes through the table read in the memory (lookup
//   stage), then the output register, before it shows on results.
// Throughput: one item per cycle unless results stalls. The code table is a
//   256-entry memory, a write and a registered read port; a write is followed
//   by a read of the same entry no sooner than the next cycle: no forwarding.
// Reset: arst_n clears the per-entry valid bits (every entry reads as pass
//   through), the squeeze memory, the count and squeeze_enable. No sweep, the
//   block takes items in the first cycle after reset.
// Stall: while results is stalled the output register holds; one more item
//   waits in the lookup stage, then items.ready drops.
module byte_translate_delete_squeeze_unit import btds_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	btds_item_if.sink     items,
	btds_result_if.source results,
	btds_cfg_if.sink      cfg
);

	logic [TABLE_DEPTH-1:0] entry_valid_q;
	logic                   squeeze_q;
	logic                   prev_valid_q;
	logic [BYTE_W-1:0]      prev_byte_q;
	count_t                 count_q;

	logic                   s1_valid_q;
	logic                   is_end_s1;
	logic                   hit_s1;
	logic [BYTE_W-1:0]      byte_s1;

	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   out_end_q;
	logic [KEPT_W-1:0]      out_kept_q;

	logic                   out_free;
	logic                   s1_adv;
	logic                   in_acc;
	cmd_t                   in_cmd;
	logic                   wr_en;
	logic                   rd_en;
	logic                   enter_s1;
	logic [CODE_W-1:0]      rd_code;
	logic [CODE_W-1:0]      code;
	logic                   translate;
	logic [BYTE_W-1:0]      val;
	logic                   emit;
	logic [WIDE_W-1:0]      count_wide;

	// handshakes
	assign out_free    = !out_valid_q || results.ready;
	assign s1_adv      = s1_valid_q && out_free;
	assign items.ready = !s1_valid_q || out_free;
	assign in_acc      = items.valid && items.ready;
	assign in_cmd      = cmd_t'(items.cmd);
	assign cfg.ready   = 1'b1;

	// decode the accepted item
	always_comb begin
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		enter_s1 = 1'b0;
		unique case (in_cmd)
			CMD_WRITE: wr_en = in_acc;
			CMD_DATA: begin
				rd_en    = in_acc;
				enter_s1 = in_acc;
			end
			CMD_END:   enter_s1 = in_acc;
			CMD_SPARE: enter_s1 = 1'b0;
			default:   enter_s1 = 1'b0;
		endcase
	end

	btds_ram #(
		.WIDTH (CODE_W),
		.DEPTH (TABLE_DEPTH)
	) u_code_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (items.entry_index),
		.wr_data (items.entry_code),
		.rd_en   (rd_en),
		.rd_addr (items.data_byte),
		.rd_data (rd_code)
	);

	// lookup stage payload
	always_ff @(posedge clk) begin
		if (rd_en || (enter_s1 && items.ready)) begin
			is_end_s1 <= (in_cmd == CMD_END);
			hit_s1    <= entry_valid_q[items.data_byte];
			byte_s1   <= items.data_byte;
		end
	end

	// translate and squeeze
	always_comb begin
		code       = hit_s1 ? rd_code : '0;
		translate  = (code != '0);
		val        = translate ? code[BYTE_W-1:0] : byte_s1;
		emit       = is_end_s1 || (!code[CODE_W-1] &&
			!(squeeze_q && translate && prev_valid_q && (prev_byte_q == val)));
		count_wide = WIDE_W'(count_q);
	end

	// control state: valid bits, lookup stage, squeeze memory, count, output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			squeeze_q     <= 1'b0;
			prev_valid_q  <= 1'b0;
			prev_byte_q   <= '0;
			count_q       <= '0;
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				squeeze_q <= cfg.data;
			end
			if (wr_en) begin
				entry_valid_q[items.entry_index] <= 1'b1;
			end
			if (items.ready) begin
				s1_valid_q <= enter_s1;
			end
			if (s1_adv) begin
				if (is_end_s1) begin
					prev_valid_q <= 1'b0;
					prev_byte_q  <= '0;
					count_q      <= '0;
				end else if (!code[CODE_W-1]) begin
					if (squeeze_q) begin
						prev_valid_q <= translate;
						prev_byte_q  <= translate ? val : '0;
					end
					if (emit && (count_q != COUNT_MAX)) begin
						count_q <= count_q + count_t'(1);
					end
				end
			end
			if (out_free) begin
				out_valid_q <= s1_adv && emit;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && s1_adv && emit) begin
			out_byte_q <= is_end_s1 ? '0 : val;
			out_end_q  <= is_end_s1;
			out_kept_q <= is_end_s1 ? count_wide[KEPT_W-1:0] : '0;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.out_byte   = out_byte_q;
	assign results.is_end     = out_end_q;
	assign results.kept_count = out_kept_q;

endmodule
